// ----- design/llu_pkg.sv -----
// ----------------------------------------------------------------------------
// llu_pkg - shared types and constants for the line list with undo
// Opcodes, status codes, field widths and the control word that the
// top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package llu_pkg;

    // Default sizing
    localparam int DEPTH_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 16;

    // Fixed field widths of the command and response beats
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int ST_W     = 2;
    localparam int LCOUNT_W = 7;

    // Cells per first-level group of the read tree
    localparam int GROUP = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UNDO   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_NOUNDO = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Broadcast to every cell; the do_* strobes are already qualified
    typedef struct packed {
        logic             do_ins;
        logic             do_del;
        logic             do_undo;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

// ----- design/llu_ifs.sv -----
// ----------------------------------------------------------------------------
// llu_ifs - command and response channels of the line list
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface llu_cmd_if #(
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [llu_pkg::OP_W-1:0]   op;
    logic [llu_pkg::POS_W-1:0]  position;
    logic [HANDLE_BITS-1:0]     handle_in;

    modport source (output valid, output op, output position, output handle_in,
                    input ready);
    modport sink   (input valid, input op, input position, input handle_in,
                    output ready);
endinterface

interface llu_rsp_if #(
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [llu_pkg::ST_W-1:0]     status;
    logic [llu_pkg::LCOUNT_W-1:0] line_count;
    logic [HANDLE_BITS-1:0]       handle_out;
    logic                         undo_ready;

    modport source (output valid, output status, output line_count,
                    output handle_out, output undo_ready, input ready);
    modport sink   (input valid, input status, input line_count,
                    input handle_out, input undo_ready, output ready);
endinterface

// ----- design/line_list_with_undo_unit.sv -----
// ----------------------------------------------------------------------------
// line_list_with_undo_unit - ordered list of line handles with single undo
// Positional insert, delete and read over a chain of list cells, with a
// one-level snapshot for undo.
// ----------------------------------------------------------------------------
// Each command beat gives one response beat: the list cells shift, snapshot or
// restore in the accept cycle, and the read or removed handle comes out of a
// two-level OR tree over the cells, whose group registers load at accept and
// feed the response register. Commands are taken back to back, one per cycle,
// as long as the response side keeps up; a response left waiting holds one
// more command in the tree stage before the command side stalls. Positions
// are one-based; rejected commands leave the list and the snapshot unchanged.
// Entries at or above the count hold stale data and are never shown.
// ----------------------------------------------------------------------------
module line_list_with_undo_unit #(
    parameter int DEPTH       = llu_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    llu_cmd_if.sink   i_cmd,
    llu_rsp_if.source o_rsp
);
    import llu_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // List state
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_shadow_count, n_shadow_count;
    logic             r_armed, n_armed;

    // Tree stage
    logic             r_pend;
    t_status          r_p_status;
    logic [CNT_W-1:0] r_p_count;
    logic             r_p_armed;
    logic             r_p_tap;

    // Response register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [CNT_W-1:0]       r_out_count;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic                   r_out_armed;

    logic                   cmd_fire;
    logic                   out_free;
    logic [CW-1:0]          pos_c;
    logic [CW-1:0]          cnt_c;
    logic                   pos_zero;
    logic                   full;
    t_status                status;
    logic                   tap;
    logic                   do_ins;
    logic                   do_del;
    logic                   do_undo;
    t_cell_ctrl             ctrl;
    logic [HANDLE_BITS-1:0] entries [DEPTH];
    logic [HANDLE_BITS-1:0] taps    [DEPTH];
    logic [HANDLE_BITS-1:0] tree_value;

    // Handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = !r_pend || out_free;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // Command decode and checks
    assign pos_c    = CW'(i_cmd.position);
    assign cnt_c    = CW'(r_count);
    assign pos_zero = (i_cmd.position == '0);
    assign full     = (r_count == CNT_W'(DEPTH));

    always_comb begin
        status  = ST_OK;
        tap     = 1'b0;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_undo = 1'b0;
        unique case (t_op'(i_cmd.op))
            OP_INSERT: begin
                if (pos_zero || (pos_c > cnt_c + CW'(1))) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos_zero || (pos_c > cnt_c)) begin
                    status = ST_BADPOS;
                end else begin
                    do_del = 1'b1;
                    tap    = 1'b1;
                end
            end
            OP_UNDO: begin
                if (!r_armed) begin
                    status = ST_NOUNDO;
                end else begin
                    do_undo = 1'b1;
                end
            end
            OP_READ: begin
                if (pos_zero || (pos_c > cnt_c)) begin
                    status = ST_BADPOS;
                end else begin
                    tap = 1'b1;
                end
            end
            default: begin
                status = ST_BADPOS;
            end
        endcase
    end

    // Next count, snapshot count and undo flag
    always_comb begin
        n_count        = r_count;
        n_shadow_count = r_shadow_count;
        n_armed        = r_armed;
        if (cmd_fire) begin
            if (do_ins) begin
                n_shadow_count = r_count;
                n_armed        = 1'b1;
                n_count        = r_count + CNT_W'(1);
            end else if (do_del) begin
                n_shadow_count = r_count;
                n_armed        = 1'b1;
                n_count        = r_count - CNT_W'(1);
            end else if (do_undo) begin
                n_count = r_shadow_count;
                n_armed = 1'b0;
            end
        end
    end

    // Broadcast to the cells
    assign ctrl.do_ins  = cmd_fire && do_ins;
    assign ctrl.do_del  = cmd_fire && do_del;
    assign ctrl.do_undo = cmd_fire && do_undo;
    assign ctrl.pos     = i_cmd.position;

    // Cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [HANDLE_BITS-1:0] left;
        logic [HANDLE_BITS-1:0] right;
        if (j == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = entries[j-1];
        end
        if (j == DEPTH - 1) begin : g_last
            assign right = entries[j];
        end else begin : g_mid_r
            assign right = entries[j+1];
        end
        llu_cell #(
            .INDEX       (j),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_handle (i_cmd.handle_in),
            .i_left   (left),
            .i_right  (right),
            .o_entry  (entries[j]),
            .o_tap    (taps[j])
        );
    end

    llu_rtree #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_rtree (
        .i_clk   (i_clk),
        .i_load  (cmd_fire),
        .i_taps  (taps),
        .o_value (tree_value)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_shadow_count <= '0;
            r_armed        <= 1'b0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_shadow_count <= n_shadow_count;
            r_armed        <= n_armed;
            if (cmd_fire) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tree stage and response payload
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_p_status <= status;
            r_p_count  <= n_count;
            r_p_armed  <= n_armed;
            r_p_tap    <= tap;
        end
        if (r_pend && out_free) begin
            r_out_status <= r_p_status;
            r_out_count  <= r_p_count;
            r_out_armed  <= r_p_armed;
            r_out_handle <= r_p_tap ? tree_value : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.line_count = LCOUNT_W'(r_out_count);
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.undo_ready = r_out_armed;

endmodule

// ----- design/llu_cell.sv -----
// ----------------------------------------------------------------------------
// llu_cell - one slot of the line list
// Holds one live entry and its snapshot copy. Shifts from the left neighbor
// on insert, from the right neighbor on delete, restores on undo, and offers
// its entry to the read tree when the command addresses it.
// ----------------------------------------------------------------------------
module llu_cell #(
    parameter int INDEX       = 0,
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  llu_pkg::t_cell_ctrl     i_ctrl,
    input  logic [HANDLE_BITS-1:0]  i_handle,
    input  logic [HANDLE_BITS-1:0]  i_left,
    input  logic [HANDLE_BITS-1:0]  i_right,
    output logic [HANDLE_BITS-1:0]  o_entry,
    output logic [HANDLE_BITS-1:0]  o_tap
);
    import llu_pkg::*;

    // Wide enough for both the one-based slot number and the position field
    localparam int SLOT_BITS = $clog2(INDEX + 2);
    localparam int SW = ((SLOT_BITS > POS_W) ? SLOT_BITS : POS_W) + 1;
    localparam logic [SW-1:0] SLOT = SW'(INDEX + 1);

    logic [HANDLE_BITS-1:0] r_entry, n_entry;
    logic [HANDLE_BITS-1:0] r_shadow, n_shadow;
    logic                   at_pos;
    logic                   past_pos;

    assign at_pos   = (SW'(i_ctrl.pos) == SLOT);
    assign past_pos = (SLOT > SW'(i_ctrl.pos));

    // Next entry and snapshot
    always_comb begin
        n_entry  = r_entry;
        n_shadow = r_shadow;
        if (i_ctrl.do_ins) begin
            n_shadow = r_entry;
            if (at_pos) begin
                n_entry = i_handle;
            end else if (past_pos) begin
                n_entry = i_left;
            end
        end else if (i_ctrl.do_del) begin
            n_shadow = r_entry;
            if (at_pos || past_pos) begin
                n_entry = i_right;
            end
        end else if (i_ctrl.do_undo) begin
            n_entry = r_shadow;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_shadow <= n_shadow;
    end

    assign o_entry = r_entry;
    assign o_tap   = at_pos ? r_entry : '0;

endmodule

// ----- design/llu_rtree.sv -----
// ----------------------------------------------------------------------------
// llu_rtree - registered OR tree over the cell taps
// At most one cell drives a nonzero tap. The first level ORs groups of cells
// into registers at command accept; the second level ORs the group registers.
// ----------------------------------------------------------------------------
module llu_rtree #(
    parameter int DEPTH       = llu_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [HANDLE_BITS-1:0]  i_taps [DEPTH],
    output logic [HANDLE_BITS-1:0]  o_value
);
    import llu_pkg::*;

    localparam int NGRP = (DEPTH + GROUP - 1) / GROUP;

    logic [HANDLE_BITS-1:0] taps_pad [NGRP*GROUP];
    logic [HANDLE_BITS-1:0] r_grp [NGRP];
    logic [HANDLE_BITS-1:0] n_grp [NGRP];

    // Pad the last group with zeros
    for (genvar t = 0; t < NGRP*GROUP; t++) begin : g_pad
        if (t < DEPTH) begin : g_live
            assign taps_pad[t] = i_taps[t];
        end else begin : g_zero
            assign taps_pad[t] = '0;
        end
    end

    // First level
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int m = 0; m < GROUP; m++) begin
                n_grp[g] = n_grp[g] | taps_pad[g*GROUP + m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    // Second level
    always_comb begin
        o_value = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

// ----- design/llu_checker.sv -----
// ----------------------------------------------------------------------------
// llu_checker - port-level checks for the line list
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module llu_checker #(
    parameter int DEPTH       = llu_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = llu_pkg::HANDLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [llu_pkg::ST_W-1:0]      i_status,
    input logic [llu_pkg::LCOUNT_W-1:0]  i_line_count,
    input logic [HANDLE_BITS-1:0]        i_handle_out,
    input logic                          i_undo_ready
);
    import llu_pkg::*;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (32'(i_line_count) <= 32'(DEPTH)))
        else $error("line count above capacity");

    // Rejected commands carry no handle
    a_reject_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status != ST_OK)) |-> (i_handle_out == '0))
        else $error("handle on a rejected command");

    // Nothing to undo means no snapshot is armed
    a_noundo_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == ST_NOUNDO)) |-> !i_undo_ready)
        else $error("undo refused while armed");

    // A stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_line_count)
             && $stable(i_handle_out) && $stable(i_undo_ready)))
        else $error("response beat changed while stalled");

endmodule

bind line_list_with_undo_unit llu_checker #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
) u_llu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_line_count (o_rsp.line_count),
    .i_handle_out (o_rsp.handle_out),
    .i_undo_ready (o_rsp.undo_ready)
);
